// ===== rtl/sct_pkg.sv =====
// Shared widths, stage-enable and inter-module bundle types for the sphere collision test.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

	// Port field widths
	localparam int COORD_W    = 24;   // signed Q15.8 coordinate
	localparam int AXIS_W     = 16;   // signed Q1.14 axis component
	localparam int LEN_W      = 24;   // unsigned Q16.8 radius sum / length
	localparam int S_DATA_W   = 240;  // 6 coords + 3 axis + radius + length, whole bytes
	localparam int S_USER_W   = 1;
	localparam int M_DATA_W   = 8;    // hit, padded to a byte

	// Datapath widths
	localparam int DIFF_W     = COORD_W + 1;          // v = sphere - other
	localparam int VPROD_W    = 2 * DIFF_W;           // signed v component squared
	localparam int VSQ_W      = 2 * DIFF_W - 1;       // |v component|^2 magnitude
	localparam int DPROD_W    = 2 * AXIS_W;           // signed d component squared
	localparam int DSQ_W      = 2 * AXIS_W - 1;       // |d component|^2 magnitude
	localparam int DOT_W      = DIFF_W + AXIS_W;      // one term of v.d
	localparam int RR_W       = 2 * LEN_W;            // R^2 and L^2
	localparam int VV_W       = VSQ_W + 1;            // sum of three v terms
	localparam int DD_W       = DSQ_W + 1;            // sum of three d terms
	localparam int T_W        = DOT_W + 1;            // signed v.d
	localparam int TMAG_W     = T_W - 1;              // t when known positive

	// Split of wide operands into 32-bit low words for the second multiply
	localparam int LO_W       = 32;
	localparam int THI_W      = TMAG_W - LO_W;
	localparam int VVHI_W     = VV_W - LO_W;
	localparam int RRHI_W     = RR_W - LO_W;
	localparam int WIDE_W     = 84;                   // holds every product and R^2*dd + t^2

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Stage-3 results handed to the wide multiply stages
	typedef struct packed {
		logic                   cyl;
		logic [VV_W-1:0]        vv;
		logic [DD_W-1:0]        dd;
		logic [RR_W-1:0]        rr;
		logic [RR_W-1:0]        ll;
		logic signed [T_W-1:0]  t;
	} front_out_t;

	// Stage-5 results handed to the decision stage
	typedef struct packed {
		logic              cyl;
		logic              tpos;
		logic              sph_hit;
		logic [WIDE_W-1:0] lhs;
		logic [WIDE_W-1:0] rd;
		logic [WIDE_W-1:0] ld;
		logic [WIDE_W-1:0] tt;
	} wide_out_t;

endpackage

`default_nettype wire

// ===== rtl/sphere_collision_test.sv =====
// Top level of the sphere collision test: stream ports, valid/flow control, stage modules.
// Depends on sct_pkg, sct_front, sct_wide_mul and sct_decide.
//
//  Channel  | Direction | Signals                         | Contents
//  ---------+-----------+---------------------------------+----------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser | one test: coordinates, axis,
//           |           |                                 | radius sum, length; tuser = action
//  m_*      | out       | m_tvalid m_tready m_tdata       | one hit bit per accepted test
//
// Throughput: one test per cycle while m_tready does not stall the output; each test passes
// through the six register stages (offset, squares, sums, partial products, wide adds,
// compare) in order, and m_tvalid is the valid bit of the last.
// Reset: arst_n clears the stage valid bits only; datapath registers carry no reset.
// Stalls: each stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and s_tready stays high until all six stages hold a result and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module sphere_collision_test
	import sct_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// s_tdata, low bit up: sphere_x, sphere_y, sphere_z, other_x, other_y, other_z,
	// axis_x, axis_y, axis_z, reach, cyl_length
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// s_tuser: action (0 sphere, 1 cylinder)
	input  wire logic [S_USER_W-1:0] s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// m_tdata, low bit up: hit, then zero padding
	output logic [M_DATA_W-1:0]      m_tdata
);

	// Unpack the input transaction
	logic signed [COORD_W-1:0] sphere_x, sphere_y, sphere_z;
	logic signed [COORD_W-1:0] other_x, other_y, other_z;
	logic signed [AXIS_W-1:0]  axis_x, axis_y, axis_z;
	logic [LEN_W-1:0]          reach, cyl_length;

	assign sphere_x   = s_tdata[0*COORD_W +: COORD_W];
	assign sphere_y   = s_tdata[1*COORD_W +: COORD_W];
	assign sphere_z   = s_tdata[2*COORD_W +: COORD_W];
	assign other_x    = s_tdata[3*COORD_W +: COORD_W];
	assign other_y    = s_tdata[4*COORD_W +: COORD_W];
	assign other_z    = s_tdata[5*COORD_W +: COORD_W];
	assign axis_x     = s_tdata[6*COORD_W +: AXIS_W];
	assign axis_y     = s_tdata[6*COORD_W + AXIS_W +: AXIS_W];
	assign axis_z     = s_tdata[6*COORD_W + 2*AXIS_W +: AXIS_W];
	assign reach      = s_tdata[6*COORD_W + 3*AXIS_W +: LEN_W];
	assign cyl_length = s_tdata[6*COORD_W + 3*AXIS_W + LEN_W +: LEN_W];

	// Valid bits, one per stage; stage 6 is the output register
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	stage_en_t en;

	// A stage advances when it is empty or its successor advances
	assign en.s6 = !valid_s6 || m_tready;
	assign en.s5 = !valid_s5 || en.s6;
	assign en.s4 = !valid_s4 || en.s5;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	front_out_t front_s3;
	wide_out_t  wide_s5;
	logic       hit_s6;

	// Offsets, narrow products and sums
	sct_front u_front (
		.clk        (clk),
		.en         (en),
		.action     (s_tuser[0]),
		.sphere_x   (sphere_x),
		.sphere_y   (sphere_y),
		.sphere_z   (sphere_z),
		.other_x    (other_x),
		.other_y    (other_y),
		.other_z    (other_z),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.axis_z     (axis_z),
		.reach      (reach),
		.cyl_length (cyl_length),
		.front_s3   (front_s3)
	);

	// Split wide products into 32-bit partial products, then recombine
	sct_wide_mul u_wide_mul (
		.clk      (clk),
		.en       (en),
		.front_s3 (front_s3),
		.wide_s5  (wide_s5)
	);

	// Final comparisons into the output register
	sct_decide u_decide (
		.clk     (clk),
		.en      (en),
		.wide_s5 (wide_s5),
		.hit_s6  (hit_s6)
	);

	assign m_tvalid = valid_s6;
	assign m_tdata  = {{(M_DATA_W-1){1'b0}}, hit_s6};

	// Back-pressure only when every stage is occupied and the output is stalled
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5
			&& valid_s6 && !m_tready))
		else $error("s_tready low with a free pipeline slot");

	// An accepted transaction occupies stage 1 in the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted transaction lost at stage 1");

	// A stalled middle stage keeps its item
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en.s3) |=> valid_s3)
		else $error("stage 3 item dropped during stall");

	// Sphere mode passes the stage-4 compare straight through
	a_sphere_path: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s6 && valid_s5 && !wide_s5.cyl) |=> (hit_s6 == $past(wide_s5.sph_hit)))
		else $error("sphere-mode hit differs from center-distance compare");

	// A cylinder test with t <= 0 never reports a hit
	a_end1_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s6 && valid_s5 && wide_s5.cyl && !wide_s5.tpos) |=> !hit_s6)
		else $error("cylinder hit reported behind the first end");

endmodule

`default_nettype wire

// ===== rtl/sct_front.sv =====
// Stages 1-3: center offset, narrow squares and dot-product terms, and their sums.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_front
	import sct_pkg::*;
(
	input  wire logic                      clk,
	input  wire stage_en_t                 en,
	input  wire logic                      action,
	input  wire logic signed [COORD_W-1:0] sphere_x,
	input  wire logic signed [COORD_W-1:0] sphere_y,
	input  wire logic signed [COORD_W-1:0] sphere_z,
	input  wire logic signed [COORD_W-1:0] other_x,
	input  wire logic signed [COORD_W-1:0] other_y,
	input  wire logic signed [COORD_W-1:0] other_z,
	input  wire logic signed [AXIS_W-1:0]  axis_x,
	input  wire logic signed [AXIS_W-1:0]  axis_y,
	input  wire logic signed [AXIS_W-1:0]  axis_z,
	input  wire logic [LEN_W-1:0]          reach,
	input  wire logic [LEN_W-1:0]          cyl_length,
	output front_out_t                     front_s3
);

	// Stage 1: offsets
	logic                      cyl_s1;
	logic signed [DIFF_W-1:0]  vx_s1, vy_s1, vz_s1;
	logic signed [AXIS_W-1:0]  dx_s1, dy_s1, dz_s1;
	logic [LEN_W-1:0]          rs_s1, len_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			cyl_s1 <= action;
			vx_s1  <= DIFF_W'(sphere_x) - DIFF_W'(other_x);
			vy_s1  <= DIFF_W'(sphere_y) - DIFF_W'(other_y);
			vz_s1  <= DIFF_W'(sphere_z) - DIFF_W'(other_z);
			dx_s1  <= axis_x;
			dy_s1  <= axis_y;
			dz_s1  <= axis_z;
			rs_s1  <= reach;
			len_s1 <= cyl_length;
		end
	end

	// Stage 2: one multiply per term
	logic signed [VPROD_W-1:0] vxx_p, vyy_p, vzz_p;
	logic signed [DPROD_W-1:0] dxx_p, dyy_p, dzz_p;

	assign vxx_p = VPROD_W'(vx_s1) * VPROD_W'(vx_s1);
	assign vyy_p = VPROD_W'(vy_s1) * VPROD_W'(vy_s1);
	assign vzz_p = VPROD_W'(vz_s1) * VPROD_W'(vz_s1);
	assign dxx_p = DPROD_W'(dx_s1) * DPROD_W'(dx_s1);
	assign dyy_p = DPROD_W'(dy_s1) * DPROD_W'(dy_s1);
	assign dzz_p = DPROD_W'(dz_s1) * DPROD_W'(dz_s1);

	logic                     cyl_s2;
	logic [VSQ_W-1:0]         vxx_s2, vyy_s2, vzz_s2;
	logic [DSQ_W-1:0]         dxx_s2, dyy_s2, dzz_s2;
	logic signed [DOT_W-1:0]  vdx_s2, vdy_s2, vdz_s2;
	logic [RR_W-1:0]          rr_s2, ll_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cyl_s2 <= cyl_s1;
			vxx_s2 <= vxx_p[VSQ_W-1:0];
			vyy_s2 <= vyy_p[VSQ_W-1:0];
			vzz_s2 <= vzz_p[VSQ_W-1:0];
			dxx_s2 <= dxx_p[DSQ_W-1:0];
			dyy_s2 <= dyy_p[DSQ_W-1:0];
			dzz_s2 <= dzz_p[DSQ_W-1:0];
			vdx_s2 <= DOT_W'(vx_s1) * DOT_W'(dx_s1);
			vdy_s2 <= DOT_W'(vy_s1) * DOT_W'(dy_s1);
			vdz_s2 <= DOT_W'(vz_s1) * DOT_W'(dz_s1);
			rr_s2  <= RR_W'(rs_s1) * RR_W'(rs_s1);
			ll_s2  <= RR_W'(len_s1) * RR_W'(len_s1);
		end
	end

	// Stage 3: three-term sums
	always_ff @(posedge clk) begin
		if (en.s3) begin
			front_s3.cyl <= cyl_s2;
			front_s3.vv  <= VV_W'(vxx_s2) + VV_W'(vyy_s2) + VV_W'(vzz_s2);
			front_s3.dd  <= DD_W'(dxx_s2) + DD_W'(dyy_s2) + DD_W'(dzz_s2);
			front_s3.t   <= T_W'(vdx_s2) + T_W'(vdy_s2) + T_W'(vdz_s2);
			front_s3.rr  <= rr_s2;
			front_s3.ll  <= ll_s2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sct_wide_mul.sv =====
// Stages 4-5: wide products t^2, vv*dd, rr*dd and ll*dd from 32-bit partial products.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_wide_mul
	import sct_pkg::*;
(
	input  wire logic       clk,
	input  wire stage_en_t  en,
	input  wire front_out_t front_s3,
	output wide_out_t       wide_s5
);

	logic [TMAG_W-1:0] tmag;
	logic [LO_W-1:0]   t_lo, vv_lo, rr_lo, ll_lo;
	logic [THI_W-1:0]  t_hi;
	logic [VVHI_W-1:0] vv_hi;
	logic [RRHI_W-1:0] rr_hi, ll_hi;

	// t is only used when positive, so its low bits are its magnitude
	assign tmag  = front_s3.t[TMAG_W-1:0];
	assign t_lo  = tmag[LO_W-1:0];
	assign t_hi  = tmag[TMAG_W-1:LO_W];
	assign vv_lo = front_s3.vv[LO_W-1:0];
	assign vv_hi = front_s3.vv[VV_W-1:LO_W];
	assign rr_lo = front_s3.rr[LO_W-1:0];
	assign rr_hi = front_s3.rr[RR_W-1:LO_W];
	assign ll_lo = front_s3.ll[LO_W-1:0];
	assign ll_hi = front_s3.ll[RR_W-1:LO_W];

	// Stage 4: partial products, each at most 32 x 32
	logic                        cyl_s4, tpos_s4, sph_hit_s4;
	logic [2*LO_W-1:0]           tll_s4, vdl_s4, rdl_s4, ldl_s4;
	logic [LO_W+THI_W-1:0]       tlh_s4;
	logic [2*THI_W-1:0]          thh_s4;
	logic [VVHI_W+DD_W-1:0]      vdh_s4;
	logic [RRHI_W+DD_W-1:0]      rdh_s4, ldh_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			cyl_s4     <= front_s3.cyl;
			tpos_s4    <= !front_s3.t[T_W-1] && (front_s3.t != '0);
			sph_hit_s4 <= front_s3.vv < VV_W'(front_s3.rr);
			tll_s4     <= (2*LO_W)'(t_lo) * (2*LO_W)'(t_lo);
			tlh_s4     <= (LO_W+THI_W)'(t_lo) * (LO_W+THI_W)'(t_hi);
			thh_s4     <= (2*THI_W)'(t_hi) * (2*THI_W)'(t_hi);
			vdl_s4     <= (2*LO_W)'(vv_lo) * (2*LO_W)'(front_s3.dd);
			vdh_s4     <= (VVHI_W+DD_W)'(vv_hi) * (VVHI_W+DD_W)'(front_s3.dd);
			rdl_s4     <= (2*LO_W)'(rr_lo) * (2*LO_W)'(front_s3.dd);
			rdh_s4     <= (RRHI_W+DD_W)'(rr_hi) * (RRHI_W+DD_W)'(front_s3.dd);
			ldl_s4     <= (2*LO_W)'(ll_lo) * (2*LO_W)'(front_s3.dd);
			ldh_s4     <= (RRHI_W+DD_W)'(ll_hi) * (RRHI_W+DD_W)'(front_s3.dd);
		end
	end

	// Stage 5: align and add the partial products; the t cross term counts twice
	always_ff @(posedge clk) begin
		if (en.s5) begin
			wide_s5.cyl     <= cyl_s4;
			wide_s5.tpos    <= tpos_s4;
			wide_s5.sph_hit <= sph_hit_s4;
			wide_s5.tt      <= WIDE_W'(tll_s4) + (WIDE_W'(tlh_s4) << (LO_W + 1))
				+ (WIDE_W'(thh_s4) << (2 * LO_W));
			wide_s5.lhs     <= WIDE_W'(vdl_s4) + (WIDE_W'(vdh_s4) << LO_W);
			wide_s5.rd      <= WIDE_W'(rdl_s4) + (WIDE_W'(rdh_s4) << LO_W);
			wide_s5.ld      <= WIDE_W'(ldl_s4) + (WIDE_W'(ldh_s4) << LO_W);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sct_decide.sv =====
// Stage 6: radial and end-cap comparisons, mode select, registered hit result.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_decide
	import sct_pkg::*;
(
	input  wire logic      clk,
	input  wire stage_en_t en,
	input  wire wide_out_t wide_s5,
	output logic           hit_s6
);

	logic [WIDE_W-1:0] rhs;
	logic              radial_out, end2_out;

	assign rhs        = wide_s5.rd + wide_s5.tt;
	assign radial_out = wide_s5.lhs > rhs;
	assign end2_out   = wide_s5.tt > wide_s5.ld;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			if (wide_s5.cyl) begin
				hit_s6 <= wide_s5.tpos && !radial_out && !end2_out;
			end else begin
				hit_s6 <= wide_s5.sph_hit;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/collision_checker.sv =====
// Checker for the sphere collision test: watches both stream channels, predicts the hit bit.
// Depends on sct_pkg for the field widths; instantiated beside the block by the testbench.
`timescale 1ns / 1ps

module collision_checker
	import sct_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	// s_tdata, low bit up: sphere_x, sphere_y, sphere_z, other_x, other_y, other_z,
	// axis_x, axis_y, axis_z, reach, cyl_length
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// s_tuser: action (0 sphere, 1 cylinder)
	input  wire logic [S_USER_W-1:0] s_tuser,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	// m_tdata, low bit up: hit, then zero padding
	input  wire logic [M_DATA_W-1:0] m_tdata,
	output int                       errors,
	output int                       pending
);

	localparam int AXIS_LSB = 6 * COORD_W;
	localparam int RAD_LSB  = AXIS_LSB + 3 * AXIS_W;
	localparam int LEN_LSB  = RAD_LSB + LEN_W;

	logic hits_due [$];

	// Exact squared-term collision test; products kept in 128 bits so nothing overflows.
	function automatic logic collides(input logic cyl, input logic [S_DATA_W-1:0] d);
		logic signed [COORD_W-1:0] sph [3];
		logic signed [COORD_W-1:0] oth [3];
		logic signed [AXIS_W-1:0]  axs [3];
		longint v [3];
		longint a [3];
		longint vv, dd, t;
		longint unsigned rad, len;
		logic [127:0] w_vv, w_dd, w_rr, w_ll, w_tt;
		int i;
		for (i = 0; i < 3; i++) begin
			sph[i] = d[i * COORD_W +: COORD_W];
			oth[i] = d[(3 + i) * COORD_W +: COORD_W];
			axs[i] = d[AXIS_LSB + i * AXIS_W +: AXIS_W];
			v[i]   = longint'(sph[i]) - longint'(oth[i]);
			a[i]   = longint'(axs[i]);
		end
		rad  = d[RAD_LSB +: LEN_W];
		len  = d[LEN_LSB +: LEN_W];
		vv   = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		dd   = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		t    = v[0] * a[0] + v[1] * a[1] + v[2] * a[2];
		w_vv = vv;
		w_dd = dd;
		w_rr = rad * rad;
		w_ll = len * len;
		w_tt = t;
		w_tt = w_tt * w_tt;
		if (!cyl)
			return w_vv < w_rr;
		// behind the first end (or a zero axis)
		if (t <= 0)
			return 1'b0;
		// too far from the axis; a radial distance equal to the radius still hits
		if (w_vv * w_dd > w_rr * w_dd + w_tt)
			return 1'b0;
		// beyond the far end
		return !(w_tt > w_ll * w_dd);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				hits_due.push_back(collides(s_tuser[0], s_tdata));
			if (m_tvalid && m_tready) begin
				if (hits_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual hit=%0b",
						$time, m_tdata[0]);
					errors++;
				end else if (m_tdata[0] !== hits_due[0]) begin
					$display("%0t: hit mismatch, expected %0b, actual %0b",
						$time, hits_due[0], m_tdata[0]);
					errors++;
					void'(hits_due.pop_front());
				end else begin
					void'(hits_due.pop_front());
				end
			end
			pending = hits_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the sphere collision test bench: clock, reset, test stimulus, result backpressure.
// Depends on sct_pkg, the block sphere_collision_test and collision_checker.
`timescale 1ns / 1ps

module testbench
	import sct_pkg::*;
();

	// One test, laid out exactly as s_tdata: first member lands in the top bits.
	typedef struct packed {
		logic [LEN_W-1:0]          cyl_length;
		logic [LEN_W-1:0]          reach;
		logic signed [AXIS_W-1:0]  axis_z;
		logic signed [AXIS_W-1:0]  axis_y;
		logic signed [AXIS_W-1:0]  axis_x;
		logic signed [COORD_W-1:0] other_z;
		logic signed [COORD_W-1:0] other_y;
		logic signed [COORD_W-1:0] other_x;
		logic signed [COORD_W-1:0] sphere_z;
		logic signed [COORD_W-1:0] sphere_y;
		logic signed [COORD_W-1:0] sphere_x;
	} test_fields_t;

	localparam longint CMAX = 64'sd8388607;
	localparam longint CMIN = -64'sd8388608;
	localparam longint LMAX = 64'sd16777215;
	localparam longint ONE  = 64'sd16384;      // unit axis component in Q1.14

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [S_USER_W-1:0] s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	int                  errors;
	int                  pending;
	bit                  no_gaps;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sphere_collision_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	collision_checker collision_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	function automatic longint clamp_coord(input longint x);
		return (x > CMAX) ? CMAX : (x < CMIN) ? CMIN : x;
	endfunction

	function automatic longint clamp_len(input longint x);
		return (x > LMAX) ? LMAX : (x < 0) ? 64'sd0 : x;
	endfunction

	// Signed value of random magnitude below 2^bits.
	function automatic longint rnd_signed(input int bits);
		longint m;
		m = $urandom_range(0, (1 << bits) - 1);
		return ($urandom_range(0, 1) == 1) ? -m : m;
	endfunction

	// Land a radius or length right around a boundary, now and then well off it.
	function automatic longint near(input real x);
		longint b;
		b = longint'(x);
		if ($urandom_range(0, 4) == 0)
			b = b + rnd_signed($urandom_range(0, 20));
		else
			b = b + int'($urandom_range(0, 6)) - 3;
		return clamp_len(b);
	endfunction

	function automatic test_fields_t make_fields(
		input longint sx, sy, sz, ox, oy, oz, ax, ay, az, rad, len);
		test_fields_t f;
		f.sphere_x   = sx[COORD_W-1:0];
		f.sphere_y   = sy[COORD_W-1:0];
		f.sphere_z   = sz[COORD_W-1:0];
		f.other_x    = ox[COORD_W-1:0];
		f.other_y    = oy[COORD_W-1:0];
		f.other_z    = oz[COORD_W-1:0];
		f.axis_x     = ax[AXIS_W-1:0];
		f.axis_y     = ay[AXIS_W-1:0];
		f.axis_z     = az[AXIS_W-1:0];
		f.reach      = rad[LEN_W-1:0];
		f.cyl_length = len[LEN_W-1:0];
		return f;
	endfunction

	// Build one random test. Mostly geometry placed near the hit boundaries (sphere touch,
	// radial distance, far end), the rest raw noise over every bit.
	task automatic make_random(output logic cyl, output test_fields_t f);
		logic [255:0] raw;
		longint o [3];
		longint s [3];
		longint a [3];
		real    p [3];
		real    dd, dn, t, vv, k, span, pd, rad, len;
		int     kind, i;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			for (i = 0; i < 8; i++)
				raw[i * 32 +: 32] = $urandom;
			f   = raw[S_DATA_W-1:0];
			cyl = raw[255];
		end else begin
			cyl = (kind >= 55);
			for (i = 0; i < 3; i++) begin
				o[i] = rnd_signed($urandom_range(0, 23));
				a[i] = rnd_signed($urandom_range(0, 15));
			end
			if (a[0] == 0 && a[1] == 0 && a[2] == 0)
				a[0] = ONE;
			dd   = real'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
			dn   = $sqrt(dd);
			span = real'(64'sd1 << $urandom_range(2, 20));
			k    = real'(int'($urandom_range(0, 1200))) / 1000.0 - 0.2;
			for (i = 0; i < 3; i++)
				p[i] = real'(rnd_signed($urandom_range(0, cyl ? 18 : 23)));
			if (cyl) begin
				// keep the side offset square to the axis, then slide along it
				pd = (p[0] * a[0] + p[1] * a[1] + p[2] * a[2]) / dd;
				for (i = 0; i < 3; i++)
					p[i] = p[i] - pd * a[i] + k * span * a[i] / dn;
			end
			for (i = 0; i < 3; i++)
				s[i] = clamp_coord(o[i] + longint'(p[i]));
			// take the geometry from the clamped fields, not from the intent
			vv = 0.0;
			t  = 0.0;
			for (i = 0; i < 3; i++) begin
				vv = vv + real'(s[i] - o[i]) * real'(s[i] - o[i]);
				t  = t + real'(s[i] - o[i]) * real'(a[i]);
			end
			if (cyl) begin
				rad = vv - t * t / dd;
				rad = (rad > 0.0) ? $sqrt(rad) : 0.0;
				len = ((t < 0.0) ? -t : t) / dn;
				f = make_fields(s[0], s[1], s[2], o[0], o[1], o[2], a[0], a[1], a[2],
					near(rad), near(len));
			end else begin
				f = make_fields(s[0], s[1], s[2], o[0], o[1], o[2], a[0], a[1], a[2],
					near($sqrt(vv)), longint'($urandom_range(0, 16777215)));
			end
		end
	endtask

	// Offer one test and hold it until the block takes it.
	task automatic send_test(input logic cyl, input test_fields_t f);
		int gap;
		gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= f;
		s_tuser  <= cyl;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
	endtask

	// Stimulus and verdict.
	initial begin
		logic         cyl;
		test_fields_t f;
		int           n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		no_gaps  = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// sphere: zero radius, zero distance, exact touch (no hit), just inside
		send_test(1'b0, make_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_test(1'b0, make_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
		send_test(1'b0, make_fields(768, 1024, 0, 0, 0, 0, CMIN, CMAX, 1, 1280, LMAX));
		send_test(1'b0, make_fields(768, 1024, 0, 0, 0, 0, -ONE, ONE, -1, 1281, 0));
		// sphere: opposite corners and x ends of the coordinate range with the largest radius, coincident centers
		send_test(1'b0, make_fields(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0, LMAX, 0));
		send_test(1'b0, make_fields(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, LMAX, 0));
		send_test(1'b0, make_fields(CMAX, 0, 0, CMIN, 0, 0, 0, 0, 0, LMAX, LMAX));
		send_test(1'b0, make_fields(-100, -200, 300, -100, -200, 300, 0, 0, 0, 1, 0));
		// cylinder: zero axis, behind the first end, square to the axis
		send_test(1'b1, make_fields(1000, 0, 0, 0, 0, 0, 0, 0, 0, LMAX, LMAX));
		send_test(1'b1, make_fields(-1000, 0, 0, 0, 0, 0, ONE, 0, 0, LMAX, LMAX));
		send_test(1'b1, make_fields(0, 500, 0, 0, 0, 0, ONE, 0, 0, LMAX, LMAX));
		// cylinder: radial distance exactly the radius still hits, one less misses
		send_test(1'b1, make_fields(100, 30, 40, 0, 0, 0, ONE, 0, 0, 50, 1000));
		send_test(1'b1, make_fields(100, 30, 40, 0, 0, 0, ONE, 0, 0, 49, 1000));
		// cylinder: projection exactly the length still hits, one less misses
		send_test(1'b1, make_fields(100, 0, 0, 0, 0, 0, ONE, 0, 0, 10, 100));
		send_test(1'b1, make_fields(100, 0, 0, 0, 0, 0, ONE, 0, 0, 10, 99));
		// cylinder: short axis that is not unit length, both boundaries touched
		send_test(1'b1, make_fields(30, 40, 7, 0, 0, 0, 3, 4, 0, 7, 50));
		send_test(1'b1, make_fields(30, 40, 7, 0, 0, 0, 3, 4, 0, 7, 49));
		send_test(1'b1, make_fields(30, 40, 7, 0, 0, 0, 3, 4, 0, 6, 50));
		// cylinder: extreme coordinates and axis components, zero radius on the axis
		send_test(1'b1, make_fields(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
			32767, 32767, 32767, LMAX, LMAX));
		send_test(1'b1, make_fields(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
			-32768, -32768, -32768, LMAX, LMAX));
		send_test(1'b1, make_fields(CMIN, 0, 0, 0, 0, 0, -32768, 0, 0, 0, LMAX));
		drain();

		for (n = 0; n < 450; n++) begin
			// back-to-back window while the receiver holds off
			no_gaps = (n >= 100 && n < 220);
			if (n == 300)
				drain();
			make_random(cyl, f);
			send_test(cyl, f);
		end
		drain();
		repeat (12) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, one long hold-off so the pipeline fills and s_tready
	// drops, and a stretch with no stalls at all.
	initial begin
		int stall;
		int taken;
		m_tready = 1'b0;
		taken    = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 150)
				stall = 90;
			else if (taken >= 300 && taken < 380)
				stall = 0;
			else
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sct_pkg.sv
rtl/sct_front.sv
rtl/sct_wide_mul.sv
rtl/sct_decide.sv
rtl/sphere_collision_test.sv
tb/collision_checker.sv
tb/testbench.sv
